// ===== rtl/core/dual_class_fifo_oldest_first_macros.svh =====
// Assertion macros for the two-class FIFO.
`ifndef DUAL_CLASS_FIFO_OLDEST_FIRST_MACROS_SVH
`define DUAL_CLASS_FIFO_OLDEST_FIRST_MACROS_SVH

`ifndef SYNTHESIS

`define DCFO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define DCFO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DCFO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define DCFO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dcfo_pkg.sv =====
`timescale 1ns / 1ps

package dcfo_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 256;
    localparam int DEFAULT_ID_BITS     = 16;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OUT_ID_W = 16;

    localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ_ANY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEQ_C1 = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DEQ_C0 = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== rtl/core/dcfo_ram.sv =====
`timescale 1ns / 1ps

module dcfo_ram #(
    parameter int WIDTH = dcfo_pkg::DEFAULT_ID_BITS,
    parameter int DEPTH = dcfo_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dcfo_queue.sv =====
`timescale 1ns / 1ps

module dcfo_queue #(
    parameter int DEPTH = dcfo_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int WIDTH = dcfo_pkg::DEFAULT_ID_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcfo_pkg::t_q_ctrl i_ctrl,
    input  logic [WIDTH-1:0]  i_wdata,
    output dcfo_pkg::t_q_stat o_stat,
    output logic [WIDTH-1:0]  o_head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    // The memory reads the head entry every cycle, so the data is valid in the
    // cycle after the head pointer settles.
    dcfo_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.push),
        .i_waddr (r_tail),
        .i_wdata (i_wdata),
        .i_raddr (r_head),
        .o_rdata (o_head_data)
    );

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_tail  = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_head  = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

endmodule

// ===== rtl/core/dual_class_fifo_oldest_first.sv =====
`timescale 1ns / 1ps
// Two FIFOs of item ids, one for class 0 and one for class 1, each kept in
// its own single-port-write, registered-read memory.
// Input channel (i_in_valid / o_in_ready): i_kind selects enqueue of i_item_id
// into the queue of i_item_class, dequeue of class 0, dequeue of class 1, or
// dequeue of whichever head id is smaller (class 1 on a tie).
// Output channel (o_out_valid / i_out_ready): one result per request, with
// o_status ok, empty or full, and the dequeued id and class (zero otherwise).
// Each request passes through the transfer cycle, in which the memories
// read the current head entries, and the execute state, which uses that
// read data and updates the pointers. The result is valid in the cycle after
// the execute state completes, and no request is taken during execution.
// The result register lets a new request be taken while a result waits. If
// the receiver stalls with a result still held, the next request waits in
// its execute cycle until the result register is free.
// Reset clears all pointers and counts, so both queues start empty; the
// memories need no clearing.
`include "dual_class_fifo_oldest_first_macros.svh"

module dual_class_fifo_oldest_first #(
    parameter int QUEUE_DEPTH = dcfo_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_BITS     = dcfo_pkg::DEFAULT_ID_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dcfo_pkg::KIND_W-1:0]     i_kind,
    input  logic [15:0]                     i_item_id,
    input  logic                            i_item_class,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dcfo_pkg::STATUS_W-1:0]   o_status,
    output logic [dcfo_pkg::OUT_ID_W-1:0]   o_out_id,
    output logic                            o_out_class
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [dcfo_pkg::KIND_W-1:0] r_kind;
    logic [ID_BITS-1:0]          r_id;
    logic                        r_class;

    logic                            r_out_valid;
    logic [dcfo_pkg::STATUS_W-1:0]   r_out_status;
    logic [dcfo_pkg::OUT_ID_W-1:0]   r_out_id;
    logic                            r_out_class;

    logic [ID_BITS-1:0]            w_in_id;
    logic [ID_BITS-1:0]            w_res_id;
    logic [dcfo_pkg::OUT_ID_W-1:0] w_res_id16;
    logic [ID_BITS-1:0]            w_head0;
    logic [ID_BITS-1:0]            w_head1;

    dcfo_pkg::t_q_ctrl w_ctrl0, w_ctrl1;
    dcfo_pkg::t_q_stat w_stat0, w_stat1;

    logic                          w_accept;
    logic                          w_done;
    logic                          w_push0, w_push1, w_take0, w_take1;
    logic [dcfo_pkg::STATUS_W-1:0] w_status;

    generate
        if (ID_BITS >= dcfo_pkg::OUT_ID_W) begin : g_wide_id
            assign w_in_id    = ID_BITS'(i_item_id);
            assign w_res_id16 = w_res_id[dcfo_pkg::OUT_ID_W-1:0];
        end else begin : g_narrow_id
            assign w_in_id    = i_item_id[ID_BITS-1:0];
            assign w_res_id16 = dcfo_pkg::OUT_ID_W'(w_res_id);
        end
    endgenerate

    dcfo_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_BITS)
    ) u_queue0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl0),
        .i_wdata     (r_id),
        .o_stat      (w_stat0),
        .o_head_data (w_head0)
    );

    dcfo_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_BITS)
    ) u_queue1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl1),
        .i_wdata     (r_id),
        .o_stat      (w_stat1),
        .o_head_data (w_head1)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_done     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_push0  = 1'b0;
        w_push1  = 1'b0;
        w_take0  = 1'b0;
        w_take1  = 1'b0;
        w_status = dcfo_pkg::ST_OK;
        case (r_kind)
            dcfo_pkg::KIND_ENQ: begin
                if (r_class ? w_stat1.full : w_stat0.full) begin
                    w_status = dcfo_pkg::ST_FULL;
                end else begin
                    w_push0 = !r_class;
                    w_push1 = r_class;
                end
            end
            dcfo_pkg::KIND_DEQ_C0: begin
                w_take0 = !w_stat0.empty;
            end
            dcfo_pkg::KIND_DEQ_C1: begin
                w_take1 = !w_stat1.empty;
            end
            dcfo_pkg::KIND_DEQ_ANY: begin
                if (!w_stat0.empty && !w_stat1.empty) begin
                    w_take0 = (w_head0 < w_head1);
                    w_take1 = !(w_head0 < w_head1);
                end else begin
                    w_take0 = !w_stat0.empty;
                    w_take1 = !w_stat1.empty;
                end
            end
            default: begin
                w_status = dcfo_pkg::ST_EMPTY;
            end
        endcase
        if (r_kind != dcfo_pkg::KIND_ENQ && !w_take0 && !w_take1) begin
            w_status = dcfo_pkg::ST_EMPTY;
        end
    end

    assign w_res_id = w_take0 ? w_head0 : (w_take1 ? w_head1 : '0);

    assign w_ctrl0.push = w_done && w_push0;
    assign w_ctrl0.pop  = w_done && w_take0;
    assign w_ctrl1.push = w_done && w_push1;
    assign w_ctrl1.pop  = w_done && w_take1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_id    <= w_in_id;
            r_class <= i_item_class;
        end
        if (w_done) begin
            r_out_status <= w_status;
            r_out_id     <= w_res_id16;
            r_out_class  <= w_take1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_id    = r_out_id;
    assign o_out_class = r_out_class;

    `DCFO_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC,
        "Accepted request did not enter the execute state.")

    `DCFO_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n,
        (w_ctrl0.push && w_stat0.full) || (w_ctrl1.push && w_stat1.full), 1'b0,
        "Push issued into a full queue.")

    `DCFO_ASSERT_NOW(a_fail_has_zero_payload, i_clk, i_rst_n,
        r_out_valid && r_out_status != dcfo_pkg::ST_OK && r_kind != dcfo_pkg::KIND_ENQ,
        r_out_id == '0 && r_out_class == 1'b0,
        "Empty result carries a nonzero id or class.")

    `DCFO_ASSERT_NEXT(a_done_sets_valid, i_clk, i_rst_n, w_done, r_out_valid,
        "Completed request did not load the result register.")

endmodule
